FILE: src/tsf_pkg.sv
// shared types, constants and register indexes for the timestamp to sample frame block
`timescale 1ns / 1ps
package tsf_pkg;

    localparam int          MAX_SAMPLE_RATE_DEF = 768000;
    localparam int          ID_WIDTH_DEF        = 16;
    localparam logic [63:0] NS_PER_SEC          = 64'd1000000000;

    // one second is 1953125 << 9; 2^20 < 1953125 < 2^21
    localparam int          NS_SHIFT   = 9;
    localparam logic [63:0] NS_ODD     = 64'd1953125;
    localparam int          NS_ODD_LOG = 21;

    localparam int TIME_W   = 64;
    localparam int TAG_W    = 16;
    localparam int RATE_W   = 20;
    localparam int SECS_W   = 35;   // 2^64 / 1e9 < 2^35
    localparam int REM_W    = 30;   // remainder below 1e9
    localparam int PROD_W   = REM_W + RATE_W;
    localparam int FRAC_W   = RATE_W;
    localparam int LO_W     = 18;
    localparam int HI_W     = SECS_W - LO_W;
    localparam int FRAMES_W = 56;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        ST_MAPPED   = 3'd0,
        ST_INVALID  = 3'd1,
        ST_STALE    = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_PAUSED   = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE  = 3'd0,
        CFG_ANCHOR_TIME  = 3'd1,
        CFG_ANCHOR_FRAME = 3'd2,
        CFG_WIN_START    = 3'd3,
        CFG_WIN_END      = 3'd4,
        CFG_PAUSED       = 3'd5,
        CFG_CLOCK_ID     = 3'd6,
        CFG_PRODUCER_ID  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] request_time_ns;
        logic [TAG_W-1:0]  expected_owner;
        logic [TAG_W-1:0]  expected_epoch;
        logic [TAG_W-1:0]  expected_generation;
        logic [TAG_W-1:0]  expected_revision;
        logic [TAG_W-1:0]  expected_producer_domain;
        logic [TAG_W-1:0]  expected_producer_gen;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [TIME_W-1:0] sample_frame;
    } t_res;

endpackage

FILE: src/timestamp_to_sample_frame.sv
// top level: timestamp to audio sample frame mapping through a correlation anchor
`timescale 1ns / 1ps
//  channel   direction  handshake              payload
//  request   in         i_req_valid/o_req_stall  t_req
//  result    out        o_res_valid/i_res_stall  t_res
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  one transaction per cycle sustained while the result is not stalled; the pipeline stages from
//  acceptance to result are input, checks, 2 stages dividing by 1e9, remainder, multiply,
//  2 stages dividing by 1e9, sum, anchor
//  each division by 1e9 is a shift plus a reciprocal multiply split over two stages
//  a stalled result freezes the whole pipeline; request stall follows it directly
//  synchronous active-low reset clears valid bits and loads register defaults
module timestamp_to_sample_frame
    import tsf_pkg::*;
#(
    parameter int MAX_SAMPLE_RATE = tsf_pkg::MAX_SAMPLE_RATE_DEF,
    parameter int ID_WIDTH        = tsf_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  tsf_pkg::t_req                 i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output tsf_pkg::t_res                 o_res,
    input  logic                          i_cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsf_pkg::TIME_W-1:0]    i_cfg_data
);
    // configuration registers
    logic [RATE_W-1:0] r_sample_rate;
    logic [TIME_W-1:0] r_anchor_time, r_anchor_frame, r_win_start, r_win_end;
    logic              r_paused;
    logic [63:0]       r_clock_id;
    logic [47:0]       r_prod_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate  <= RATE_W'(48000);
            r_anchor_time  <= '0;
            r_anchor_frame <= '0;
            r_win_start    <= '0;
            r_win_end      <= '0;
            r_paused       <= 1'b0;
            r_clock_id     <= '0;
            r_prod_id      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_RATE:  r_sample_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_ANCHOR_TIME:  r_anchor_time  <= i_cfg_data;
                CFG_ANCHOR_FRAME: r_anchor_frame <= i_cfg_data;
                CFG_WIN_START:    r_win_start    <= i_cfg_data;
                CFG_WIN_END:      r_win_end      <= i_cfg_data;
                CFG_PAUSED:       r_paused       <= i_cfg_data[0];
                CFG_CLOCK_ID:     r_clock_id     <= i_cfg_data;
                CFG_PRODUCER_ID:  r_prod_id      <= i_cfg_data[47:0];
            endcase
        end
    end

    // whole pipeline advances unless the result register is held
    logic en;
    assign en          = !(o_res_valid && i_res_stall);
    assign o_req_stall = o_res_valid && i_res_stall;

    // stage 0: capture request
    logic r0_vld;
    t_req r0_req;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_req_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_req <= i_req;
        end
    end

    // stage 1: checks in priority order, direction and distance from the anchor
    logic [ID_WIDTH-1:0] owner, epoch, gen, rev, odom, pdom, pgen;
    assign owner = r_clock_id[48 +: ID_WIDTH];
    assign epoch = r_clock_id[32 +: ID_WIDTH];
    assign gen   = r_clock_id[16 +: ID_WIDTH];
    assign rev   = r_clock_id[0  +: ID_WIDTH];
    assign odom  = r_prod_id[32 +: ID_WIDTH];
    assign pdom  = r_prod_id[16 +: ID_WIDTH];
    assign pgen  = r_prod_id[0  +: ID_WIDTH];

    t_status           n1_status;
    logic              n1_after;
    logic [TIME_W-1:0] n1_delta;
    logic [TIME_W-1:0] t;
    assign t = r0_req.request_time_ns;

    always_comb begin
        priority if (owner == '0 || epoch == '0 || gen == '0 || rev == '0 ||
                     r_sample_rate == '0 ||
                     {4'd0, r_sample_rate} > 24'(MAX_SAMPLE_RATE) ||
                     odom == '0 || pdom == '0 || pgen == '0 ||
                     r_win_start > r_anchor_time || r_anchor_time > r_win_end) begin
            n1_status = ST_INVALID;
        end else if (r0_req.expected_owner[ID_WIDTH-1:0] != owner ||
                     r0_req.expected_epoch[ID_WIDTH-1:0] != epoch ||
                     r0_req.expected_generation[ID_WIDTH-1:0] != gen ||
                     r0_req.expected_revision[ID_WIDTH-1:0] != rev ||
                     r0_req.expected_producer_domain[ID_WIDTH-1:0] != pdom ||
                     r0_req.expected_producer_gen[ID_WIDTH-1:0] != pgen) begin
            n1_status = ST_STALE;
        end else if (t < r_win_start || t > r_win_end) begin
            n1_status = ST_OUTSIDE;
        end else if (r_paused) begin
            n1_status = ST_PAUSED;
        end else begin
            n1_status = ST_MAPPED;
        end
        n1_after = (t >= r_anchor_time);
        n1_delta = n1_after ? t - r_anchor_time : r_anchor_time - t;
    end

    logic              r1_vld;
    t_status           r1_status;
    logic              r1_after;
    logic [TIME_W-1:0] r1_delta;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_status <= n1_status;
            r1_after  <= n1_after;
            r1_delta  <= n1_delta;
        end
    end

    // whole seconds of the distance; low distance bits ride along for the remainder
    logic                  d1_vld;
    logic [SECS_W-1:0]     d1_secs;
    logic [4+REM_W-1:0]    d1_side;
    tsf_div #(
        .NUM_W  (TIME_W),
        .Q_W    (SECS_W),
        .SIDE_W (4 + REM_W)
    ) u_div_sec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r1_vld),
        .i_num  (r1_delta),
        .i_side ({r1_status, r1_after, r1_delta[REM_W-1:0]}),
        .o_vld  (d1_vld),
        .o_quo  (d1_secs),
        .o_side (d1_side)
    );

    logic [3:0]       d1_ctl;
    logic [REM_W-1:0] d1_low;
    assign {d1_ctl, d1_low} = d1_side;

    // leftover nanoseconds: remainder is below 2^30, so low bits suffice
    localparam logic [REM_W-1:0] NS_LOW = NS_PER_SEC[REM_W-1:0];
    logic              rs_vld;
    logic [SECS_W-1:0] rs_secs;
    logic [REM_W-1:0]  rs_rem;
    logic [3:0]        rs_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_vld <= 1'b0;
        end else if (en) begin
            rs_vld <= d1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            rs_secs <= d1_secs;
            rs_rem  <= d1_low - REM_W'(d1_secs[REM_W-1:0] * NS_LOW);
            rs_side <= d1_ctl;
        end
    end

    // stage 2: scale both parts by the rate; seconds product split in two halves
    logic                   r2_vld;
    logic [LO_W+RATE_W-1:0] r2_plo;
    logic [HI_W+RATE_W-1:0] r2_phi;
    logic [PROD_W-1:0]      r2_prod;
    logic [3:0]             r2_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= rs_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_plo  <= (LO_W+RATE_W)'(rs_secs[LO_W-1:0]) * (LO_W+RATE_W)'(r_sample_rate);
            r2_phi  <= (HI_W+RATE_W)'(rs_secs[SECS_W-1:LO_W]) * (HI_W+RATE_W)'(r_sample_rate);
            r2_prod <= PROD_W'(rs_rem) * PROD_W'(r_sample_rate);
            r2_side <= rs_side;
        end
    end

    // truncated sub-second frames
    localparam int SIDE2_W = 4 + LO_W + RATE_W + HI_W + RATE_W;
    logic               d2_vld;
    logic [FRAC_W-1:0]  d2_frac;
    logic [SIDE2_W-1:0] d2_side;
    tsf_div #(
        .NUM_W  (PROD_W),
        .Q_W    (FRAC_W),
        .SIDE_W (SIDE2_W)
    ) u_div_frac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_num  (r2_prod),
        .i_side ({r2_side, r2_plo, r2_phi}),
        .o_vld  (d2_vld),
        .o_quo  (d2_frac),
        .o_side (d2_side)
    );

    logic [LO_W+RATE_W-1:0] d2_plo;
    logic [HI_W+RATE_W-1:0] d2_phi;
    logic [3:0]             d2_ctl;
    assign {d2_ctl, d2_plo, d2_phi} = d2_side;

    // stage 3: total frame distance (never wraps: below 2^56)
    logic                r3_vld;
    logic [FRAMES_W-1:0] r3_frames;
    t_status             r3_status;
    logic                r3_after;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= d2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_frames <= FRAMES_W'(d2_plo) + FRAMES_W'({d2_phi, {LO_W{1'b0}}})
                       + FRAMES_W'(d2_frac);
            r3_status <= t_status'(d2_ctl[3:1]);
            r3_after  <= d2_ctl[0];
        end
    end

    // stage 4: apply to anchor frame, carry or borrow means overflow
    logic [TIME_W:0] sum, dif;
    t_res            n4_res;
    assign sum = {1'b0, r_anchor_frame} + (TIME_W+1)'(r3_frames);
    assign dif = {1'b0, r_anchor_frame} - (TIME_W+1)'(r3_frames);

    always_comb begin
        n4_res.status       = r3_status;
        n4_res.sample_frame = '0;
        if (r3_status == ST_MAPPED) begin
            if (r3_after ? sum[TIME_W] : dif[TIME_W]) begin
                n4_res.status = ST_OVERFLOW;
            end else begin
                n4_res.sample_frame = r3_after ? sum[TIME_W-1:0] : dif[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (en) begin
            o_res_valid <= r3_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res <= n4_res;
        end
    end

endmodule

FILE: src/tsf_div.sv
// pipelined division by one second in nanoseconds: power of two shifted out, then reciprocal multiply
`timescale 1ns / 1ps
module tsf_div #(
    parameter int NUM_W  = 64,
    parameter int Q_W    = 35,
    parameter int SIDE_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);
    import tsf_pkg::*;

    // floor(x * M / 2^S) equals floor(x / odd part) for every x below 2^X_W
    localparam int X_W = NUM_W - NS_SHIFT;
    localparam int XL  = X_W / 2;
    localparam int XH  = X_W - XL;
    localparam int M_W = X_W + 1;
    localparam int ML  = M_W / 2;
    localparam int MH  = M_W - ML;
    localparam int S   = X_W + NS_ODD_LOG;
    localparam int P_W = X_W + M_W;
    localparam int R_W = S + Q_W;
    localparam logic [127:0] M_FULL =
        ((128'd1 << S) + 128'(NS_ODD) - 128'd1) / 128'(NS_ODD);
    localparam logic [M_W-1:0] M    = M_W'(M_FULL);
    localparam logic [ML-1:0]  M_LO = M[ML-1:0];
    localparam logic [MH-1:0]  M_HI = M[M_W-1:ML];

    logic [XL-1:0] x_lo;
    logic [XH-1:0] x_hi;
    assign x_lo = i_num[NS_SHIFT +: XL];
    assign x_hi = i_num[NS_SHIFT+XL +: XH];

    // stage a: four partial products
    logic              r_a_vld;
    logic [XL+ML-1:0]  r_pp_ll;
    logic [XL+MH-1:0]  r_pp_lh;
    logic [XH+ML-1:0]  r_pp_hl;
    logic [XH+MH-1:0]  r_pp_hh;
    logic [SIDE_W-1:0] r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll  <= (XL+ML)'(x_lo) * (XL+ML)'(M_LO);
            r_pp_lh  <= (XL+MH)'(x_lo) * (XL+MH)'(M_HI);
            r_pp_hl  <= (XH+ML)'(x_hi) * (XH+ML)'(M_LO);
            r_pp_hh  <= (XH+MH)'(x_hi) * (XH+MH)'(M_HI);
            r_a_side <= i_side;
        end
    end

    // stage b: sum of the partial products
    logic              r_b_vld;
    logic [R_W-1:0]    r_prod;
    logic [SIDE_W-1:0] r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= R_W'(P_W'(r_pp_ll) + (P_W'(r_pp_lh) << ML)
                             + (P_W'(r_pp_hl) << XL) + (P_W'(r_pp_hh) << (XL + ML)));
            r_b_side <= r_a_side;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_quo  = r_prod[S +: Q_W];
    assign o_side = r_b_side;

endmodule
